[rtl/gcode_line_checksum_receiver_core_assert.svh]
// ----------------------------------------------------------------------------
// G-code line receiver assertion macros
// Shorthand for the concurrent checks at the end of the receiver core.
// ----------------------------------------------------------------------------
`ifndef GCODE_LINE_CHECKSUM_RECEIVER_CORE_ASSERT_SVH
`define GCODE_LINE_CHECKSUM_RECEIVER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCLR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("receiver check failed");

// The consequent must hold in the cycle after the antecedent.
`define GCLR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("receiver check failed");

`endif

[rtl/gclr_pkg.sv]
// ----------------------------------------------------------------------------
// G-code line receiver package
// Sizes, character codes, result kinds and controller states.
// ----------------------------------------------------------------------------
package gclr_pkg;

    localparam int MAX_LINE = 64;
    localparam int ADDR_W   = $clog2(MAX_LINE);
    localparam int FILL_W   = $clog2(MAX_LINE + 1);
    localparam int CNT_W    = 31;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_D    = 8'h64;
    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_N    = 8'h6E;

    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        K_PAYLOAD = 3'd0,
        K_OK      = 3'd1,
        K_RESEND  = 3'd2,
        K_DUP     = 3'd3,
        K_COMMENT = 3'd4,
        K_END     = 3'd5,
        K_READY   = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EMIT,
        S_OK
    } t_state;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

endpackage

[rtl/gclr_in_if.sv]
// ----------------------------------------------------------------------------
// G-code line receiver input channel
// One beat carries an opcode and a received byte.
// ----------------------------------------------------------------------------
interface gclr_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

[rtl/gclr_out_if.sv]
// ----------------------------------------------------------------------------
// G-code line receiver result channel
// One beat carries a result kind, a payload byte, a count and a last flag.
// ----------------------------------------------------------------------------
interface gclr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [30:0] count;
    logic        last;

    modport source (output valid, output kind, output payload_byte, output count,
                    output last, input ready);
    modport sink   (input valid, input kind, input payload_byte, input count,
                    input last, output ready);
endinterface

[rtl/gcode_line_checksum_receiver_core.sv]
// Results are registered; a restart or a non-matching line reports in the cycle after its beat.
// Throughput: one byte per cycle while no line is being flushed and the result register is free.
// A matching line flushes its payload from the line memory byte by byte (each byte is read,
// then loaded into the result register), then reports ok; no beat is taken during the flush.
// Reset: synchronous, active low; clears counters and line state, not the line memory.
// ----------------------------------------------------------------------------
// G-code line receiver core
// Buffers a numbered, checksummed line in a memory and reports its outcome.
// ----------------------------------------------------------------------------
`include "gcode_line_checksum_receiver_core_assert.svh"

module gcode_line_checksum_receiver_core
    import gclr_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    gclr_in_if.sink        i_rx,
    gclr_out_if.source     o_res
);

    logic [7:0] mem [MAX_LINE];
    logic [7:0] r_rd_data;

    t_state             r_state, n_state;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [7:0]         r_xor, n_xor;
    logic [7:0]         r_xbl, n_xbl;
    logic               r_star, n_star;
    logic [ADDR_W-1:0]  r_first, n_first;
    logic [ADDR_W-1:0]  r_lastpos, n_lastpos;
    logic [CNT_W-1:0]   r_num, n_num;
    logic               r_num_ok, n_num_ok;
    logic [7:0]         r_sum, n_sum;
    logic               r_sum_seen, n_sum_seen;
    logic               r_sum_stop, n_sum_stop;
    logic               r_ovf, n_ovf;
    logic               r_is_end, n_is_end;
    logic               r_bang, n_bang;
    logic [CNT_W-1:0]   r_expected, n_expected;
    logic [CNT_W-1:0]   r_confirmed, n_confirmed;
    logic [FILL_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [ADDR_W-1:0]  r_end_pos, n_end_pos;

    logic               r_out_valid, n_out_valid;
    t_kind              r_out_kind, n_out_kind;
    logic [7:0]         r_out_byte, n_out_byte;
    logic [CNT_W-1:0]   r_out_count, n_out_count;
    logic               r_out_last, n_out_last;

    logic               in_fire;
    logic               out_free;
    logic               mem_we;
    logic               mem_re;
    logic [7:0]         c;
    logic               c_digit;
    logic [CNT_W+3:0]   num_next;
    logic [7:0]         sum_next;
    logic [FILL_W-1:0]  first_plus;
    logic [FILL_W-1:0]  ptr_plus;

    assign out_free = !r_out_valid || o_res.ready;
    assign i_rx.ready = (r_state == S_IDLE) && out_free;
    assign in_fire = i_rx.valid && i_rx.ready;
    assign c = i_rx.rx_byte;
    assign c_digit = is_digit(c);
    assign num_next = ({4'b0, r_num} << 3) + ({4'b0, r_num} << 1) + (CNT_W+4)'(c[3:0]);
    assign sum_next = 8'(({r_sum, 3'b0}) + ({r_sum[6:0], 1'b0}) + {4'b0, c[3:0]});
    assign first_plus = FILL_W'(r_first) + FILL_W'(1);
    assign ptr_plus = r_rd_ptr + FILL_W'(1);

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out_kind;
    assign o_res.payload_byte = r_out_byte;
    assign o_res.count        = r_out_count;
    assign o_res.last         = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_xor       = r_xor;
        n_xbl       = r_xbl;
        n_star      = r_star;
        n_first     = r_first;
        n_lastpos   = r_lastpos;
        n_num       = r_num;
        n_num_ok    = r_num_ok;
        n_sum       = r_sum;
        n_sum_seen  = r_sum_seen;
        n_sum_stop  = r_sum_stop;
        n_ovf       = r_ovf;
        n_is_end    = r_is_end;
        n_bang      = r_bang;
        n_expected  = r_expected;
        n_confirmed = r_confirmed;
        n_rd_ptr    = r_rd_ptr;
        n_end_pos   = r_end_pos;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (t_op'(i_rx.opcode) == OP_RESTART || c == CH_LF) begin
                        n_fill     = '0;
                        n_xor      = '0;
                        n_xbl      = '0;
                        n_star     = 1'b0;
                        n_first    = '0;
                        n_lastpos  = '0;
                        n_num      = '0;
                        n_num_ok   = 1'b1;
                        n_sum      = '0;
                        n_sum_seen = 1'b0;
                        n_sum_stop = 1'b0;
                        n_ovf      = 1'b0;
                        n_is_end   = 1'b0;
                        n_bang     = 1'b0;
                        n_out_valid = 1'b1;
                        n_out_byte  = '0;
                        n_out_count = '0;
                        n_out_last  = 1'b1;
                        if (t_op'(i_rx.opcode) == OP_RESTART) begin
                            n_expected  = '0;
                            n_confirmed = '0;
                            n_out_kind  = K_READY;
                        end else if (r_ovf) begin
                            n_out_kind  = K_RESEND;
                            n_out_count = r_expected;
                        end else if (r_fill == FILL_W'(3) && r_is_end) begin
                            n_out_kind = K_END;
                        end else if (r_fill != '0 && r_bang) begin
                            n_out_kind = K_COMMENT;
                        end else if (!r_star || !r_sum_seen || r_sum != r_xbl
                                     || !r_num_ok || r_num > r_expected) begin
                            n_out_kind  = K_RESEND;
                            n_out_count = r_expected;
                        end else if (r_num < r_expected) begin
                            n_out_kind = K_DUP;
                        end else begin
                            n_out_valid = 1'b0;
                            if (r_expected != CNT_MAX) begin
                                n_expected = r_expected + CNT_W'(1);
                            end
                            n_rd_ptr  = first_plus;
                            n_end_pos = r_lastpos;
                            if (first_plus < FILL_W'(r_lastpos)) begin
                                n_state = S_RD;
                            end else begin
                                n_state = S_OK;
                            end
                        end
                    end else if (c == CH_CR) begin
                        n_fill = r_fill;
                    end else if (r_fill >= FILL_W'(MAX_LINE)) begin
                        n_ovf = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        n_fill = r_fill + FILL_W'(1);
                        n_xor  = r_xor ^ c;
                        if (r_fill == '0) begin
                            n_is_end = (c == CH_E);
                            n_bang   = (c == CH_BANG);
                        end else if (r_fill == FILL_W'(1)) begin
                            n_is_end = r_is_end && (c == CH_N);
                        end else if (r_fill == FILL_W'(2)) begin
                            n_is_end = r_is_end && (c == CH_D);
                        end
                        if (c == CH_STAR) begin
                            if (!r_star) begin
                                n_first = r_fill[ADDR_W-1:0];
                            end
                            n_star     = 1'b1;
                            n_lastpos  = r_fill[ADDR_W-1:0];
                            n_xbl      = r_xor;
                            n_sum      = '0;
                            n_sum_seen = 1'b0;
                            n_sum_stop = 1'b0;
                        end else if (!r_star) begin
                            if (!c_digit) begin
                                n_num_ok = 1'b0;
                            end else if (num_next > (CNT_W+4)'(CNT_MAX)) begin
                                n_num = CNT_MAX;
                            end else begin
                                n_num = num_next[CNT_W-1:0];
                            end
                        end else if (!r_sum_stop) begin
                            if (c_digit) begin
                                n_sum      = sum_next;
                                n_sum_seen = 1'b1;
                            end else begin
                                n_sum_stop = 1'b1;
                            end
                        end
                    end
                end
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = K_PAYLOAD;
                    n_out_byte  = r_rd_data;
                    n_out_count = '0;
                    n_out_last  = 1'b0;
                    n_rd_ptr    = ptr_plus;
                    if (ptr_plus < FILL_W'(r_end_pos)) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_OK;
                    end
                end
            end
            S_OK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = K_OK;
                    n_out_byte  = '0;
                    n_out_count = r_confirmed;
                    n_out_last  = 1'b1;
                    if (r_confirmed != CNT_MAX) begin
                        n_confirmed = r_confirmed + CNT_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_fill[ADDR_W-1:0]] <= c;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_rd_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_xor       <= '0;
            r_xbl       <= '0;
            r_star      <= 1'b0;
            r_first     <= '0;
            r_lastpos   <= '0;
            r_num       <= '0;
            r_num_ok    <= 1'b1;
            r_sum       <= '0;
            r_sum_seen  <= 1'b0;
            r_sum_stop  <= 1'b0;
            r_ovf       <= 1'b0;
            r_is_end    <= 1'b0;
            r_bang      <= 1'b0;
            r_expected  <= '0;
            r_confirmed <= '0;
            r_rd_ptr    <= '0;
            r_end_pos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_xor       <= n_xor;
            r_xbl       <= n_xbl;
            r_star      <= n_star;
            r_first     <= n_first;
            r_lastpos   <= n_lastpos;
            r_num       <= n_num;
            r_num_ok    <= n_num_ok;
            r_sum       <= n_sum;
            r_sum_seen  <= n_sum_seen;
            r_sum_stop  <= n_sum_stop;
            r_ovf       <= n_ovf;
            r_is_end    <= n_is_end;
            r_bang      <= n_bang;
            r_expected  <= n_expected;
            r_confirmed <= n_confirmed;
            r_rd_ptr    <= n_rd_ptr;
            r_end_pos   <= n_end_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind  <= n_out_kind;
        r_out_byte  <= n_out_byte;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
    end

    `GCLR_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= FILL_W'(MAX_LINE))
    `GCLR_ASSERT_SAME(a_payload_not_last, o_res.valid && o_res.kind == K_PAYLOAD, !o_res.last)
    `GCLR_ASSERT_SAME(a_flush_in_range, r_state == S_EMIT, r_rd_ptr < FILL_W'(r_end_pos))
    `GCLR_ASSERT_NEXT(a_flush_blocks_input, r_state != S_IDLE, r_fill == '0)

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// G-code line receiver testbench
// Sends numbered, checksummed lines and odd ones byte by byte under random
// gaps and result stalls, predicts every outcome in a line book, and
// compares each result beat with the oldest outcome due.
// ----------------------------------------------------------------------------
module testbench;
    import gclr_pkg::*;

    typedef logic [7:0] t_line_q[$];

    typedef struct {
        t_kind           kind;
        logic [7:0]      payload_byte;
        logic [CNT_W-1:0] count;
        logic            last;
    } t_outcome;

    typedef enum {
        SF_PLAIN,
        SF_PADDED,
        SF_WRAPPED,
        SF_TRAILED,
        SF_WRONG,
        SF_MISSING
    } t_sum_form;

    class t_outcome_book;
        logic [7:0]       line_mem [0:MAX_LINE-1];
        int               fill;
        logic [7:0]       run_xor;
        logic [7:0]       xor_at_star;
        bit               star_seen;
        int               first_star;
        int               last_star;
        bit               overflowed;
        logic [CNT_W-1:0] expected_line;
        logic [CNT_W-1:0] confirmed_count;
        t_outcome         fresh[$];
        t_outcome         outcomes_due[$];
        int               fault_count;

        function new();
            clear_line();
            expected_line   = '0;
            confirmed_count = '0;
            fault_count     = 0;
        endfunction

        function void clear_line();
            fill        = 0;
            run_xor     = 8'h00;
            xor_at_star = 8'h00;
            star_seen   = 1'b0;
            first_star  = 0;
            last_star   = 0;
            overflowed  = 1'b0;
        endfunction

        function bit numeral(logic [7:0] c);
            return (c >= CH_0) && (c <= CH_9);
        endfunction

        function void post(t_kind kind, logic [7:0] pb, logic [CNT_W-1:0] cnt);
            t_outcome o;
            o.kind         = kind;
            o.payload_byte = pb;
            o.count        = cnt;
            o.last         = 1'b0;
            fresh.push_back(o);
        endfunction

        function void judge_line();
            logic [7:0] sum;
            bit         sum_seen;
            longint     num;
            if (overflowed) begin
                post(K_RESEND, 8'h00, expected_line);
                return;
            end
            if (fill == 3 && line_mem[0] == CH_E && line_mem[1] == CH_N &&
                    line_mem[2] == CH_D) begin
                post(K_END, 8'h00, '0);
                return;
            end
            if (fill > 0 && line_mem[0] == CH_BANG) begin
                post(K_COMMENT, 8'h00, '0);
                return;
            end
            if (!star_seen) begin
                post(K_RESEND, 8'h00, expected_line);
                return;
            end
            sum      = 8'h00;
            sum_seen = 1'b0;
            for (int i = last_star + 1; i < fill; i++) begin
                if (!numeral(line_mem[i]))
                    break;
                sum_seen = 1'b1;
                sum      = sum * 8'd10 + (line_mem[i] - CH_0);
            end
            if (!sum_seen || sum != xor_at_star) begin
                post(K_RESEND, 8'h00, expected_line);
                return;
            end
            num = 0;
            for (int i = 0; i < first_star; i++) begin
                if (!numeral(line_mem[i])) begin
                    post(K_RESEND, 8'h00, expected_line);
                    return;
                end
                num = num * 10 + longint'(line_mem[i] - CH_0);
                if (num > longint'(CNT_MAX))
                    num = longint'(CNT_MAX);
            end
            if (num < longint'(expected_line)) begin
                post(K_DUP, 8'h00, '0);
                return;
            end
            if (num > longint'(expected_line)) begin
                post(K_RESEND, 8'h00, expected_line);
                return;
            end
            if (expected_line != CNT_MAX)
                expected_line++;
            for (int i = first_star + 1; i < last_star; i++)
                post(K_PAYLOAD, line_mem[i], '0);
            post(K_OK, 8'h00, confirmed_count);
            if (confirmed_count != CNT_MAX)
                confirmed_count++;
        endfunction

        function void take_beat(t_op op, logic [7:0] c);
            fresh.delete();
            if (op == OP_RESTART) begin
                expected_line   = '0;
                confirmed_count = '0;
                clear_line();
                post(K_READY, 8'h00, '0);
            end else if (c == CH_LF) begin
                judge_line();
                clear_line();
            end else if (c != CH_CR) begin
                if (fill >= MAX_LINE) begin
                    overflowed = 1'b1;
                end else begin
                    if (c == CH_STAR) begin
                        if (!star_seen)
                            first_star = fill;
                        star_seen   = 1'b1;
                        last_star   = fill;
                        xor_at_star = run_xor;
                    end
                    run_xor        = run_xor ^ c;
                    line_mem[fill] = c;
                    fill++;
                end
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                outcomes_due.push_back(fresh[i]);
        endfunction

        function void match_result(logic [2:0] kind, logic [7:0] pb, logic [CNT_W-1:0] cnt,
                                   logic lst);
            t_outcome due;
            if (outcomes_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: kind %0d byte %h count %0d last %b",
                             kind, pb, cnt, lst);
                return;
            end
            due = outcomes_due.pop_front();
            if (kind !== due.kind || pb !== due.payload_byte || cnt !== due.count ||
                    lst !== due.last) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("mismatch: expected kind %0d byte %h count %0d last %b, %s",
                             due.kind, due.payload_byte, due.count, due.last,
                             $sformatf("got kind %0d byte %h count %0d last %b",
                                       kind, pb, cnt, lst));
            end
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    gclr_in_if  rx_if ();
    gclr_out_if res_if ();

    gcode_line_checksum_receiver_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    t_outcome_book outcomes;

    int         burst_left = 0;
    bit         steady     = 1'b0;
    int         bytes_sent = 0;
    logic [15:0] stall_mask = 16'hFFFF;
    logic [5:0]  stall_step = '0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (stall_step == 0)
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        res_if.ready <= stall_mask[stall_step[3:0]];
        stall_step = stall_step + 1'b1;
    end

    // A result beat is taken at the next rising edge if valid and ready hold now.
    always @(negedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            outcomes.match_result(res_if.kind, res_if.payload_byte, res_if.count, res_if.last);
    end

    task automatic send_beat(input t_op op, input logic [7:0] c);
        int gap;
        bit took;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        rx_if.valid   <= 1'b1;
        rx_if.opcode  <= op;
        rx_if.rx_byte <= c;
        do begin
            @(negedge i_clk);
            took = rx_if.ready;
            @(posedge i_clk);
        end while (!took);
        outcomes.take_beat(op, c);
        bytes_sent++;
    endtask

    task automatic send_line(input t_line_q text);
        foreach (text[i]) begin
            if ($urandom_range(0, 39) == 0)
                send_beat(OP_BYTE, CH_CR);
            send_beat(OP_BYTE, text[i]);
        end
        if ($urandom_range(0, 7) == 0)
            send_beat(OP_BYTE, CH_CR);
        send_beat(OP_BYTE, CH_LF);
    endtask

    function automatic t_line_q text_bytes(input string s);
        t_line_q q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic t_line_q random_body(input int len);
        t_line_q    q;
        logic [7:0] c;
        repeat (len) begin
            c = 8'($urandom);
            if (c == CH_LF || c == CH_CR)
                c = c ^ 8'h80;
            if ($urandom_range(0, 11) == 0)
                c = CH_STAR;
            q.push_back(c);
        end
        return q;
    endfunction

    function automatic int body_len();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(40, 62) : $urandom_range(0, 12);
    endfunction

    function automatic string dec(input longint v);
        return $sformatf("%0d", v);
    endfunction

    task automatic send_framed(input string num_text, input t_line_q body, input bit one_star,
                               input t_sum_form form);
        t_line_q    text;
        logic [7:0] sum;
        string      sum_text;
        text = text_bytes(num_text);
        if (!one_star) begin
            text.push_back(CH_STAR);
            foreach (body[i])
                text.push_back(body[i]);
        end
        sum = 8'h00;
        foreach (text[i])
            sum = sum ^ text[i];
        text.push_back(CH_STAR);
        case (form)
            SF_PLAIN:   sum_text = $sformatf("%0d", sum);
            SF_PADDED:  sum_text = $sformatf("%03d", sum);
            SF_WRAPPED: sum_text = dec(int'(sum) + 256 * int'($urandom_range(1, 3)));
            SF_TRAILED: sum_text = $sformatf("%0d ;x", sum);
            SF_WRONG:   sum_text = $sformatf("%0d", sum ^ 8'($urandom_range(1, 255)));
            default:    sum_text = ($urandom_range(0, 1) == 0) ? "" : "G";
        endcase
        text = {text, text_bytes(sum_text)};
        send_line(text);
    endtask

    initial begin
        #50_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        string   num;
        t_line_q body;
        int      pick;
        outcomes = new();
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.opcode  = 1'b0;
        rx_if.rx_byte = 8'h00;
        res_if.ready  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(OP_RESTART, 8'hFF);
        send_framed("0", text_bytes("G1 X10"), 1'b0, SF_PLAIN);
        send_framed("1", body, 1'b1, SF_PLAIN);
        send_framed("0", text_bytes("G0"), 1'b0, SF_PLAIN);
        send_framed(dec(outcomes.expected_line + 7), text_bytes("G0"), 1'b0, SF_PLAIN);
        send_framed(dec(outcomes.expected_line), text_bytes("M104"), 1'b0, SF_WRONG);
        send_framed(dec(outcomes.expected_line), text_bytes("M104"), 1'b0, SF_MISSING);
        send_line(text_bytes("G28"));
        send_line(body);
        send_line(text_bytes("!comment"));
        send_line(text_bytes("end"));
        send_line(text_bytes("new"));
        send_framed({"+", dec(outcomes.expected_line)}, text_bytes("G1"), 1'b0, SF_PLAIN);
        send_framed({" ", dec(outcomes.expected_line)}, text_bytes("G1"), 1'b0, SF_PLAIN);
        send_framed("99999999999", text_bytes("G1"), 1'b0, SF_PLAIN);
        send_framed(dec(outcomes.expected_line), text_bytes("a*b"), 1'b0, SF_TRAILED);
        send_framed({"00", dec(outcomes.expected_line)}, random_body(8), 1'b0, SF_WRAPPED);
        num = dec(outcomes.expected_line);
        send_framed(num, random_body(59 - num.len()), 1'b0, SF_PADDED);
        num = dec(outcomes.expected_line);
        send_framed(num, random_body(60 - num.len()), 1'b0, SF_PADDED);
        body = text_bytes("3*ab");
        foreach (body[i])
            send_beat(OP_BYTE, body[i]);
        send_beat(OP_RESTART, 8'h00);
        send_framed("", text_bytes("M105"), 1'b0, SF_PLAIN);
        send_framed("", text_bytes("M105"), 1'b0, SF_PLAIN);

        while (bytes_sent < 400) begin
            steady = ($urandom_range(0, 4) == 0);
            pick   = $urandom_range(0, 99);
            num    = dec(outcomes.expected_line);
            if (pick < 50) begin
                if ($urandom_range(0, 7) == 0)
                    num = {"0", num};
                send_framed(num, random_body(body_len()), $urandom_range(0, 9) == 0,
                            t_sum_form'($urandom_range(0, 3)));
            end else if (pick < 58) begin
                if (outcomes.expected_line != 0)
                    num = dec($urandom_range(0, outcomes.expected_line - 1));
                send_framed(num, random_body(body_len()), 1'b0, SF_PLAIN);
            end else if (pick < 64) begin
                num = dec(longint'(outcomes.expected_line) + $urandom_range(1, 1000));
                send_framed(num, random_body(body_len()), 1'b0, SF_PLAIN);
            end else if (pick < 72) begin
                send_framed(num, random_body(body_len()), 1'b0, SF_WRONG);
            end else if (pick < 76) begin
                send_framed(num, random_body(body_len()), 1'b0, SF_MISSING);
            end else if (pick < 80) begin
                case ($urandom_range(0, 3))
                    0:       num = {"+", num};
                    1:       num = {"-", num};
                    2:       num = {" ", num};
                    default: num = {num, "N"};
                endcase
                send_framed(num, random_body(body_len()), 1'b0, SF_PLAIN);
            end else if (pick < 84) begin
                body = random_body(body_len());
                body.push_front(CH_BANG);
                send_line(body);
            end else if (pick < 87) begin
                send_line(text_bytes("end"));
            end else if (pick < 90) begin
                body = random_body($urandom_range(0, 20));
                foreach (body[i])
                    if (body[i] == CH_STAR)
                        body[i] = 8'h23;
                send_line(body);
            end else if (pick < 93) begin
                send_framed(num, random_body($urandom_range(60, 80)), 1'b0, SF_PLAIN);
            end else if (pick < 96) begin
                send_beat(OP_RESTART, 8'($urandom));
            end else begin
                body = random_body($urandom_range(1, 10));
                foreach (body[i])
                    send_beat(OP_BYTE, body[i]);
                send_beat(OP_RESTART, 8'($urandom));
            end
        end

        rx_if.valid <= 1'b0;
        while (outcomes.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (outcomes.fault_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

[gcode_line_checksum_receiver_core.f]
+incdir+rtl
rtl/gclr_pkg.sv
rtl/gclr_in_if.sv
rtl/gclr_out_if.sv
rtl/gcode_line_checksum_receiver_core.sv
bench/testbench.sv
